// File: sv/afos_pkg.sv
// Shared types, widths and codes of the ADC frame offset and statistics unit.
`default_nettype none

package afos_pkg;

  // Field widths.
  localparam int RAW_W       = 16;
  localparam int CODE_W      = 12;
  localparam int COUNT_W     = 16;
  localparam int SUM_W       = 27;
  localparam int VALUE_W     = 28;
  localparam int LINE_W      = 2;
  localparam int KIND_W      = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Defaults of the top-level parameters.
  localparam int MAX_POINTS_DEF = 32768;
  localparam int LINE_TOTAL_DEF = 4;

  // Reset values.
  localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 16'd1024;
  localparam logic [CODE_W-1:0]  MIN_RESET         = 12'hFFF;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_POINT_COUNT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STATS_ENABLE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LINE0   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LINE1   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LINE2   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LINE3   = 3'd5;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE   = 3'd0,
    KIND_MIN      = 3'd1,
    KIND_MAX      = 3'd2,
    KIND_AVG      = 3'd3,
    KIND_INTEGRAL = 3'd4
  } kind_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_word;
  } sample_t;

  typedef struct packed {
    kind_t                     kind;
    logic [LINE_W-1:0]         line;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } result_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// File: sv/afos_stream_if.sv
// Valid/ready channel with a generic payload, used for samples, results and configuration.
`default_nettype none

interface afos_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/afos_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module afos_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [afos_pkg::SUM_W-1:0]   dividend,
  input  logic [afos_pkg::COUNT_W-1:0] divisor,
  output afos_pkg::div_status_t        status,
  output logic [afos_pkg::SUM_W-1:0]   quotient
);
  import afos_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] LastStep = STEP_W'(SUM_W - 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  dq;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] divisor_q;

  logic [COUNT_W:0]   rem_sh;
  logic [COUNT_W+1:0] diff;
  logic               ge;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh = {rem, dq[SUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, divisor_q};
    ge     = ~diff[COUNT_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        step      <= LastStep;
        dq        <= dividend;
        rem       <= '0;
        divisor_q <= divisor;
      end else if (busy) begin
        rem <= ge ? diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
        dq  <= {dq[SUM_W-2:0], ge};
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = dq;

  // A start always launches a full division.
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not go busy after start");
  // The partial remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst) busy |-> rem < divisor_q)
    else $error("divider remainder out of range");
  // Completion is never flagged while a division is running.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  // No new division is launched over a running one.
  a_no_restart: assert property (@(posedge clk) disable iff (rst) !(start && busy))
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

// File: sv/adc_frame_offset_and_stats_unit.sv
// Top level of the ADC frame offset and statistics unit.
// Raw converter words arrive in frame order, point_count samples per line for
// each line in turn. Each accepted word yields one offset-corrected sample
// (low 12 bits minus 2048 minus the line's zero offset). A word that closes a
// line is followed by minimum, maximum, average and integral of that line,
// which read as zero when statistics are disabled. Between line ends, a new
// word is taken whenever the result register is empty or being read. A word
// that closes a line holds the input until its statistics have left: the
// average comes from a restoring divider that retires one quotient bit per
// cycle over the 27-bit line sum, and the four statistics then leave through
// the result register one per cycle while the receiver keeps reading.
// Configuration writes are always taken and apply from the next accepted word.
`default_nettype none

module adc_frame_offset_and_stats_unit #(
  parameter int MAX_POINTS = afos_pkg::MAX_POINTS_DEF,
  parameter int LINE_TOTAL = afos_pkg::LINE_TOTAL_DEF
) (
  input logic           clk,
  input logic           rst,
  afos_stream_if.sink   sample_in,
  afos_stream_if.source result_out,
  afos_stream_if.sink   cfg
);
  import afos_pkg::*;

  localparam logic [COUNT_W-1:0] MaxCount  = COUNT_W'(MAX_POINTS);
  localparam logic [LINE_W:0]    LineCount = (LINE_W + 1)'(LINE_TOTAL);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT_MIN,
    ST_EMIT_MAX,
    ST_EMIT_AVG,
    ST_EMIT_INT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [COUNT_W-1:0] point_count;
  logic               stats_enable;
  logic [CODE_W-1:0]  zero_line [4];

  // Running line state.
  logic [COUNT_W-1:0] sample_index;
  logic [LINE_W-1:0]  line_index;
  logic [CODE_W-1:0]  running_min;
  logic [CODE_W-1:0]  running_max;
  logic [SUM_W-1:0]   running_sum;

  // Snapshot of a finished line.
  logic [CODE_W-1:0]  st_min;
  logic [CODE_W-1:0]  st_max;
  logic [SUM_W-1:0]   st_sum;
  logic [CODE_W-1:0]  st_bias;
  logic [COUNT_W-1:0] st_count;
  logic [LINE_W-1:0]  st_line;
  logic               st_enable;
  logic [VALUE_W-1:0] prod;

  // Result register.
  logic    out_valid;
  result_t out_data;

  // Divider connection.
  div_status_t       div_status;
  logic [SUM_W-1:0]  div_quotient;
  logic              div_start;

  logic [COUNT_W-1:0] n_eff;
  logic [CODE_W-1:0]  code;
  logic [CODE_W-1:0]  zero_cur;
  logic [CODE_W-1:0]  bias_cur;
  logic               eol;
  logic               out_free;
  logic               accept;
  logic [CODE_W-1:0]  new_min;
  logic [CODE_W-1:0]  new_max;
  logic [SUM_W-1:0]   new_sum;
  logic [LINE_W-1:0]  line_next;
  result_t            sample_res;
  result_t            stat_res;

  // Configuration write port; writes are never stalled.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= POINT_COUNT_RESET;
      stats_enable <= 1'b1;
      zero_line[0] <= '0;
      zero_line[1] <= '0;
      zero_line[2] <= '0;
      zero_line[3] <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.payload.index)
        REG_POINT_COUNT:  point_count  <= cfg.payload.data;
        REG_STATS_ENABLE: stats_enable <= cfg.payload.data[0];
        REG_ZERO_LINE0:   zero_line[0] <= cfg.payload.data[CODE_W-1:0];
        REG_ZERO_LINE1:   zero_line[1] <= cfg.payload.data[CODE_W-1:0];
        REG_ZERO_LINE2:   zero_line[2] <= cfg.payload.data[CODE_W-1:0];
        REG_ZERO_LINE3:   zero_line[3] <= cfg.payload.data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-sample datapath: clamp the count, correct the code, update the line.
  always_comb begin
    if (point_count == '0) begin
      n_eff = COUNT_W'(1);
    end else if (point_count > MaxCount) begin
      n_eff = MaxCount;
    end else begin
      n_eff = point_count;
    end
    code     = sample_in.payload.raw_word[CODE_W-1:0];
    zero_cur = zero_line[line_index];
    // 2048 plus a signed 12-bit offset always fits 0..4095: flip the sign bit.
    bias_cur = {~zero_cur[CODE_W-1], zero_cur[CODE_W-2:0]};
    eol      = ({1'b0, sample_index} + (COUNT_W + 1)'(1)) >= {1'b0, n_eff};
    new_min  = (code < running_min) ? code : running_min;
    new_max  = (code > running_max) ? code : running_max;
    new_sum  = running_sum + SUM_W'(code);
    if ({1'b0, line_index} + (LINE_W + 1)'(1) >= LineCount) begin
      line_next = '0;
    end else begin
      line_next = line_index + 1'b1;
    end

    sample_res.kind  = KIND_SAMPLE;
    sample_res.line  = line_index;
    sample_res.value = VALUE_W'(code) - VALUE_W'(bias_cur);
    sample_res.last  = ~eol;
  end

  assign out_free        = ~out_valid | result_out.ready;
  assign sample_in.ready = (state == ST_IDLE) && out_free;
  assign accept          = sample_in.valid && sample_in.ready;
  assign div_start       = accept && eol;

  // Statistic presented in each emit state.
  always_comb begin
    stat_res.line = st_line;
    stat_res.last = 1'b0;
    unique case (state)
      ST_EMIT_MIN: begin
        stat_res.kind  = KIND_MIN;
        stat_res.value = VALUE_W'(st_min) - VALUE_W'(st_bias);
      end
      ST_EMIT_MAX: begin
        stat_res.kind  = KIND_MAX;
        stat_res.value = VALUE_W'(st_max) - VALUE_W'(st_bias);
      end
      ST_EMIT_AVG: begin
        stat_res.kind  = KIND_AVG;
        stat_res.value = VALUE_W'(div_quotient) - VALUE_W'(st_bias);
      end
      ST_EMIT_INT: begin
        stat_res.kind  = KIND_INTEGRAL;
        stat_res.value = VALUE_W'(st_sum) - prod;
        stat_res.last  = 1'b1;
      end
      default: begin
        stat_res.kind  = KIND_SAMPLE;
        stat_res.value = '0;
      end
    endcase
    if (!st_enable) begin
      stat_res.value = '0;
    end
  end

  // Offset times point count for the integral, registered ahead of use.
  always_ff @(posedge clk) begin
    prod <= VALUE_W'(st_bias) * VALUE_W'(st_count);
  end

  // Sequencer, line state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      sample_index <= '0;
      line_index   <= '0;
      running_min  <= MIN_RESET;
      running_max  <= '0;
      running_sum  <= '0;
    end else begin
      if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            out_valid <= 1'b1;
            out_data  <= sample_res;
            if (eol) begin
              st_min       <= new_min;
              st_max       <= new_max;
              st_sum       <= new_sum;
              st_bias      <= bias_cur;
              st_count     <= n_eff;
              st_line      <= line_index;
              st_enable    <= stats_enable;
              sample_index <= '0;
              running_min  <= MIN_RESET;
              running_max  <= '0;
              running_sum  <= '0;
              line_index   <= line_next;
              state        <= ST_DIVIDE;
            end else begin
              running_min  <= new_min;
              running_max  <= new_max;
              running_sum  <= new_sum;
              sample_index <= sample_index + 1'b1;
            end
          end
        end
        ST_DIVIDE: begin
          if (div_status.done) begin
            state <= ST_EMIT_MIN;
          end
        end
        ST_EMIT_MIN, ST_EMIT_MAX, ST_EMIT_AVG, ST_EMIT_INT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= stat_res;
            unique case (state)
              ST_EMIT_MIN: state <= ST_EMIT_MAX;
              ST_EMIT_MAX: state <= ST_EMIT_AVG;
              ST_EMIT_AVG: state <= ST_EMIT_INT;
              default:     state <= ST_IDLE;
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result_out.valid   = out_valid;
  assign result_out.payload = out_data;

  // Divider for the line average.
  afos_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (new_sum),
    .divisor  (n_eff),
    .status   (div_status),
    .quotient (div_quotient)
  );

  // A line end starts a division and the sequencer waits on it.
  a_line_end_divides: assert property (@(posedge clk) disable iff (rst)
    accept && eol |=> state == ST_DIVIDE && div_status.busy)
    else $error("line end did not start the divider");
  // While waiting, the divider is either running or just finished.
  a_divide_tracks: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVIDE |-> div_status.busy || div_status.done)
    else $error("sequencer waits on an idle divider");
  // A pending statistic belongs to the captured line.
  a_stat_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_SAMPLE |-> out_data.line == st_line)
    else $error("statistic carries the wrong line");
  // Disabled statistics read as zero.
  a_stat_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_SAMPLE && !st_enable |-> out_data.value == '0)
    else $error("disabled statistic is not zero");

endmodule

`default_nettype wire

// File: test/adc_frame_offset_and_stats_unit_tb.sv
// Self-checking testbench for the ADC frame offset and statistics unit.
module adc_frame_offset_and_stats_unit_tb;
  import afos_pkg::*;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  localparam int IDLE_PCT     = 23;
  localparam int STUCK_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_WORDS = 120;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;

  afos_stream_if #(.payload_t(sample_t)) sample_if ();
  afos_stream_if #(.payload_t(result_t)) result_if ();
  afos_stream_if #(.payload_t(cfg_wr_t)) cfg_if ();

  adc_frame_offset_and_stats_unit DUT (
    .clk(clk),
    .rst(rst),
    .sample_in(sample_if),
    .result_out(result_if),
    .cfg(cfg_if)
  );

  // Free-running clock, period 8.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Pending stimulus and bookkeeping shared by the driver and the monitor.
  logic [RAW_W-1:0] raw_pending [$];
  cfg_wr_t          cfg_pending [$];
  int               words_left = 0;
  int               cfg_left = 0;
  int               stuck_cycles = 0;
  int               mismatches = 0;
  bit               calm = 1'b0;
  bit               word_taken = 1'b0;
  bit               cfg_taken = 1'b0;

  // Shadow of the configuration and the per-line accumulators.
  logic [COUNT_W-1:0]        point_cnt;
  bit                        stats_on;
  logic signed [CODE_W-1:0]  zero_off [LINE_TOTAL_DEF];
  logic [COUNT_W-1:0]        sample_pos;
  logic [LINE_W-1:0]         cur_line;
  logic [CODE_W-1:0]         line_min;
  logic [CODE_W-1:0]         line_max;
  logic [SUM_W-1:0]          line_sum;
  result_t                   expected_results [$];

  function automatic void expect_result(kind_t kind, logic [LINE_W-1:0] ln, longint value,
                                        bit last);
    result_t r;
    r.kind  = kind;
    r.line  = ln;
    r.value = value[VALUE_W-1:0];
    r.last  = last;
    expected_results.push_back(r);
  endfunction

  // Offset correction of one word, plus the line statistics when the word closes a line.
  function automatic void predict_word(logic [RAW_W-1:0] raw);
    logic [CODE_W-1:0] code;
    logic [LINE_W-1:0] ln;
    longint            n;
    longint            base;
    bit                closes;
    code = raw[CODE_W-1:0];
    ln   = cur_line;
    base = 2048 + longint'(zero_off[ln]);
    if (point_cnt == 0)
      n = 1;
    else if (point_cnt > MAX_POINTS_DEF)
      n = MAX_POINTS_DEF;
    else
      n = point_cnt;
    closes = (longint'(sample_pos) + 1 >= n);
    if (code < line_min) line_min = code;
    if (code > line_max) line_max = code;
    line_sum = line_sum + code;
    expect_result(KIND_SAMPLE, ln, longint'(code) - base, !closes);
    if (!closes) begin
      sample_pos = sample_pos + 1'b1;
    end else begin
      if (stats_on) begin
        expect_result(KIND_MIN, ln, longint'(line_min) - base, 1'b0);
        expect_result(KIND_MAX, ln, longint'(line_max) - base, 1'b0);
        expect_result(KIND_AVG, ln, longint'(line_sum) / n - base, 1'b0);
        expect_result(KIND_INTEGRAL, ln, longint'(line_sum) - base * n, 1'b1);
      end else begin
        expect_result(KIND_MIN, ln, 0, 1'b0);
        expect_result(KIND_MAX, ln, 0, 1'b0);
        expect_result(KIND_AVG, ln, 0, 1'b0);
        expect_result(KIND_INTEGRAL, ln, 0, 1'b1);
      end
      sample_pos = '0;
      line_min   = MIN_RESET;
      line_max   = '0;
      line_sum   = '0;
      cur_line   = (ln == LINE_TOTAL_DEF - 1) ? '0 : ln + 1'b1;
    end
  endfunction

  // Monitor: checks results, tracks register writes and predicts each accepted word.
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    bit      progress;
    progress   = 1'b0;
    word_taken = 1'b0;
    cfg_taken  = 1'b0;
    if (rst) begin
      point_cnt  = POINT_COUNT_RESET;
      stats_on   = 1'b1;
      for (int i = 0; i < LINE_TOTAL_DEF; i++) zero_off[i] = '0;
      sample_pos = '0;
      cur_line   = '0;
      line_min   = MIN_RESET;
      line_max   = '0;
      line_sum   = '0;
      expected_results.delete();
    end else begin
      if (result_if.valid && result_if.ready) begin
        progress = 1'b1;
        got = result_if.payload;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: kind %0d line %0d value %0d last %0b",
                     got.kind, got.line, got.value, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.line !== want.line ||
              got.value !== want.value || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result mismatch: expected kind %0d line %0d value %0d last %0b, %s",
                       want.kind, want.line, want.value, want.last,
                       $sformatf("got kind %0d line %0d value %0d last %0b",
                                 got.kind, got.line, got.value, got.last));
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        progress  = 1'b1;
        cfg_taken = 1'b1;
        cfg_left--;
        case (cfg_if.payload.index)
          REG_POINT_COUNT:  point_cnt   = cfg_if.payload.data;
          REG_STATS_ENABLE: stats_on    = cfg_if.payload.data[0];
          REG_ZERO_LINE0:   zero_off[0] = cfg_if.payload.data[CODE_W-1:0];
          REG_ZERO_LINE1:   zero_off[1] = cfg_if.payload.data[CODE_W-1:0];
          REG_ZERO_LINE2:   zero_off[2] = cfg_if.payload.data[CODE_W-1:0];
          REG_ZERO_LINE3:   zero_off[3] = cfg_if.payload.data[CODE_W-1:0];
          default: ;
        endcase
      end
      if (sample_if.valid && sample_if.ready) begin
        progress   = 1'b1;
        word_taken = 1'b1;
        words_left--;
        predict_word(sample_if.payload.raw_word);
      end
    end
    stuck_cycles = progress ? 0 : stuck_cycles + 1;
  end

  // Word driver: presents the next pending word, with random gaps unless calm.
  always @(negedge clk) begin
    if (!sample_if.valid || word_taken) begin
      if (!rst && raw_pending.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        sample_if.valid            <= 1'b1;
        sample_if.payload.raw_word <= raw_pending.pop_front();
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // Register write driver.
  always @(negedge clk) begin
    if (!cfg_if.valid || cfg_taken) begin
      if (!rst && cfg_pending.size() != 0) begin
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= cfg_pending.pop_front();
      end else begin
        cfg_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver stalls at random unless calm.
  always @(negedge clk) begin
    result_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog on cycles without any transaction.
  always @(negedge clk) begin
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("no transaction for %0d cycles", stuck_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [RAW_W-1:0] rand_word();
    logic [RAW_W-1:0] w;
    w = RAW_W'($urandom_range(0, 16'hFFFF));
    case ($urandom_range(0, 9))
      0: w[CODE_W-1:0] = 12'h000;
      1: w[CODE_W-1:0] = 12'hFFF;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_zero();
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
    case ($urandom_range(0, 5))
      0: d[CODE_W-1:0] = 12'h7FF;
      1: d[CODE_W-1:0] = 12'h800;
      default: ;
    endcase
    return d;
  endfunction

  task automatic push_word(input logic [RAW_W-1:0] w);
    raw_pending.push_back(w);
    words_left++;
  endtask

  // Writes one register and returns once the transaction has been taken.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_t w;
    w.index = idx;
    w.data  = data;
    cfg_pending.push_back(w);
    cfg_left++;
    while (cfg_left != 0) @(negedge clk);
  endtask

  // Waits until every word and register write is taken and every expected result has arrived.
  task automatic settle();
    while (words_left != 0 || cfg_left != 0 || expected_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin : stimulus
    logic [RAW_W-1:0]      first_frame [12];
    logic [CFG_DATA_W-1:0] d;
    int                    count;
    int                    lines;
    int                    part;
    int                    phase;
    int                    random_words;

    first_frame = '{
      16'h0000, 16'hFFFF, 16'h0800,
      16'h0FFF, 16'hF000, 16'h1234,
      16'h8001, 16'h7FFE, 16'h0555,
      16'hC800, 16'h37FF, 16'h0AAA
    };
    rst                = 1'b1;
    sample_if.valid    = 1'b0;
    sample_if.payload  = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.payload     = '0;
    result_if.ready    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // One full frame of three-sample lines with extreme offsets and codes.
    settle();
    write_reg(REG_POINT_COUNT, 16'd3);
    write_reg(REG_ZERO_LINE0, 16'h07FF);
    write_reg(REG_ZERO_LINE1, 16'hF800);
    write_reg(REG_ZERO_LINE2, 16'h0123);
    write_reg(REG_ZERO_LINE3, 16'hAFFF);
    write_reg(REG_STATS_ENABLE, 16'h0001);
    foreach (first_frame[i]) push_word(first_frame[i]);

    // A count of zero behaves as one; first with statistics off, then on.
    settle();
    write_reg(REG_POINT_COUNT, 16'd0);
    write_reg(REG_STATS_ENABLE, 16'hFFFE);
    push_word(16'h0FFF);
    push_word(16'h0000);
    push_word(16'h5A5A);
    push_word(16'hA5A5);
    settle();
    write_reg(REG_STATS_ENABLE, 16'h0001);
    push_word(16'h9ABC);
    push_word(16'h0001);

    // Count lowered below the position mid-line: the next word closes the line.
    settle();
    write_reg(REG_POINT_COUNT, 16'hFFFF);
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0000);
    repeat (4) push_word(rand_word());
    settle();
    write_reg(REG_POINT_COUNT, 16'd2);
    push_word(16'h4321);

    // Random phases of whole lines, each under fresh settings.
    random_words = 0;
    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      settle();
      count = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 24);
      write_reg(REG_POINT_COUNT, CFG_DATA_W'(count));
      d = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
      d[0] = ($urandom_range(0, 3) != 0);
      write_reg(REG_STATS_ENABLE, d);
      for (int i = 0; i < LINE_TOTAL_DEF; i++)
        write_reg(REG_ZERO_LINE0 + CFG_INDEX_W'(i), pick_zero());
      write_reg((phase % 2) ? REG_SPARE_A : REG_SPARE_B,
                CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
      calm = (phase == 0);
      lines = calm ? (48 + count - 1) / count : $urandom_range(1, 4);
      for (int i = 0; i < lines * count; i++) push_word(rand_word());
      random_words += lines * count;
      // Now and then, cut a line short by lowering the count mid-line.
      if (count > 1 && $urandom_range(0, 3) == 0) begin
        part = $urandom_range(1, count - 1);
        for (int i = 0; i < part; i++) push_word(rand_word());
        settle();
        write_reg(REG_POINT_COUNT, CFG_DATA_W'($urandom_range(1, part)));
        push_word(rand_word());
        random_words += part + 1;
      end
      settle();
      calm = 1'b0;
      phase++;
    end

    // Drain, then give the block time to show any stray result.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
sv/afos_pkg.sv
sv/afos_stream_if.sv
sv/afos_div.sv
sv/adc_frame_offset_and_stats_unit.sv
test/adc_frame_offset_and_stats_unit_tb.sv
